// File: rtl/nft_pkg.sv
package nft_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = 16;
    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 66;
    localparam int ACC_W     = 58;
    localparam int PX_W      = 49;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int STEP_W    = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POS_LIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_QUAD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_LIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_QUAD = 3'd3;

    localparam logic signed [GAIN_W-1:0] RST_POS_LIN  = 16'sd5120;
    localparam logic signed [GAIN_W-1:0] RST_POS_QUAD = 16'sd128;
    localparam logic signed [GAIN_W-1:0] RST_VEL_LIN  = 16'sd1280;
    localparam logic signed [GAIN_W-1:0] RST_VEL_QUAD = 16'sd84;

    // micro-sequence lengths
    localparam int SQ_LEN   = 3;
    localparam int PULL_LEN = 9;
    localparam int MOVE_LEN = 7;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_x;
        logic signed [DATA_W-1:0] target_y;
        logic signed [DATA_W-1:0] target_vx;
        logic signed [DATA_W-1:0] target_vy;
        logic [DT_W-1:0]          time_step;
        logic                     load_position;
        logic signed [DATA_W-1:0] ext_pos_x;
        logic signed [DATA_W-1:0] ext_pos_y;
        logic                     load_velocity;
        logic signed [DATA_W-1:0] ext_vel_x;
        logic signed [DATA_W-1:0] ext_vel_y;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ERR, ST_SQ, ST_ROOT, ST_PULL, ST_SAT, ST_MOVE, ST_DONE
    } t_state;

    // multiplier operand selection
    typedef enum logic [4:0] {
        M_NONE, M_EXX, M_EYY, M_EXL, M_EYL, M_K1EX, M_K1EY,
        M_K2PHX, M_K2PLX, M_K2PHY, M_K2PLY,
        M_VXDT, M_VYDT, M_AXDT, M_AYDT, M_ADTXDT, M_ADTYDT
    } t_msel;

    // use of the registered product
    typedef enum logic [4:0] {
        U_NONE, U_SQ_SET, U_SQ_ADD, U_PX, U_PY, U_ACCX, U_ACCY,
        U_TMPX, U_K2X, U_TMPY, U_K2Y,
        U_VDTX, U_VDTY, U_ADTX, U_ADTY, U_HALFX, U_HALFY
    } t_usel;

    typedef struct packed {
        t_msel msel;
        t_usel usel;
    } t_mop;

    typedef struct packed {
        logic load;
        logic err_ld;
        logic vsel;
        logic root_go;
        logic sat_acc;
        logic commit;
        t_mop mop;
    } t_cmd;

    typedef struct packed {
        logic root_busy;
    } t_stat;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

    function automatic t_mop sq_op(input logic [STEP_W-1:0] step);
        t_mop m;
        m = '{msel: M_NONE, usel: U_NONE};
        unique case (step)
            4'd0:    m = '{msel: M_EXX,  usel: U_NONE};
            4'd1:    m = '{msel: M_EYY,  usel: U_SQ_SET};
            4'd2:    m = '{msel: M_NONE, usel: U_SQ_ADD};
            default: m = '{msel: M_NONE, usel: U_NONE};
        endcase
        return m;
    endfunction

    function automatic t_mop pull_op(input logic [STEP_W-1:0] step);
        t_mop m;
        m = '{msel: M_NONE, usel: U_NONE};
        unique case (step)
            4'd0:    m = '{msel: M_EXL,   usel: U_NONE};
            4'd1:    m = '{msel: M_EYL,   usel: U_PX};
            4'd2:    m = '{msel: M_K1EX,  usel: U_PY};
            4'd3:    m = '{msel: M_K2PHX, usel: U_ACCX};
            4'd4:    m = '{msel: M_K2PLX, usel: U_TMPX};
            4'd5:    m = '{msel: M_K1EY,  usel: U_K2X};
            4'd6:    m = '{msel: M_K2PHY, usel: U_ACCY};
            4'd7:    m = '{msel: M_K2PLY, usel: U_TMPY};
            4'd8:    m = '{msel: M_NONE,  usel: U_K2Y};
            default: m = '{msel: M_NONE,  usel: U_NONE};
        endcase
        return m;
    endfunction

    function automatic t_mop move_op(input logic [STEP_W-1:0] step);
        t_mop m;
        m = '{msel: M_NONE, usel: U_NONE};
        unique case (step)
            4'd0:    m = '{msel: M_VXDT,   usel: U_NONE};
            4'd1:    m = '{msel: M_VYDT,   usel: U_VDTX};
            4'd2:    m = '{msel: M_AXDT,   usel: U_VDTY};
            4'd3:    m = '{msel: M_AYDT,   usel: U_ADTX};
            4'd4:    m = '{msel: M_ADTXDT, usel: U_ADTY};
            4'd5:    m = '{msel: M_ADTYDT, usel: U_HALFX};
            4'd6:    m = '{msel: M_NONE,   usel: U_HALFY};
            default: m = '{msel: M_NONE,   usel: U_NONE};
        endcase
        return m;
    endfunction

endpackage

// File: rtl/nft_sqrt.sv
module nft_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [nft_pkg::SQ_W-1:0]         i_rad,
    output logic [nft_pkg::ROOT_W-1:0]       o_root,
    output logic                             o_busy
);

    logic [nft_pkg::SQ_W-1:0]   r_rad;
    logic [nft_pkg::ROOT_W+1:0] r_rem;
    logic [nft_pkg::ROOT_W-1:0] r_root;
    logic [4:0]                 r_cnt;
    logic                       r_busy;

    logic [nft_pkg::ROOT_W+2:0] w_shift;
    logic [nft_pkg::ROOT_W+2:0] w_trial;
    logic                       w_ge;

    // one root bit per cycle: bring down two radicand bits, trial subtract
    assign w_shift = {r_rem[nft_pkg::ROOT_W:0], r_rad[nft_pkg::SQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_shift >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '1;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[nft_pkg::SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? (nft_pkg::ROOT_W+2)'(w_shift - w_trial)
                           : (nft_pkg::ROOT_W+2)'(w_shift);
            r_root <= {r_root[nft_pkg::ROOT_W-2:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_busy = r_busy;

endmodule

// File: rtl/nft_dpath.sv
module nft_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nft_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [nft_pkg::GAIN_W-1:0]         i_cfg_data,
    input  nft_pkg::t_in                       i_in_data,
    input  nft_pkg::t_cmd                      i_cmd,
    output nft_pkg::t_stat                     o_stat,
    output nft_pkg::t_out                      o_out_data
);

    logic signed [nft_pkg::GAIN_W-1:0] r_gain [4];
    nft_pkg::t_in                      r_in;
    nft_pkg::t_out                     r_out;
    logic signed [nft_pkg::DATA_W-1:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic signed [nft_pkg::DATA_W-1:0] r_ex, r_ey;
    logic                              r_vsel;
    logic signed [nft_pkg::PROD_W-1:0] r_prod, r_tmp;
    logic [nft_pkg::SQ_W-1:0]          r_sq;
    logic signed [nft_pkg::PX_W-1:0]   r_px, r_py;
    logic signed [nft_pkg::ACC_W-1:0]  r_ax, r_ay;
    logic signed [50:0]                r_npx, r_npy;
    logic signed [nft_pkg::DATA_W-1:0] r_nvx, r_nvy;
    logic signed [nft_pkg::MUL_W-1:0]  r_adtx, r_adty;

    logic signed [nft_pkg::MUL_W-1:0]  w_a, w_b;
    logic signed [nft_pkg::MUL_W-1:0]  w_k1, w_k2, w_len, w_dt;
    logic signed [nft_pkg::PROD_W-1:0] w_k2sum;
    logic [nft_pkg::ROOT_W-1:0]        w_root;
    logic                              w_busy;

    nft_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_go),
        .i_rad   (r_sq),
        .o_root  (w_root),
        .o_busy  (w_busy)
    );

    assign o_stat.root_busy = w_busy;
    assign o_out_data       = r_out;

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= nft_pkg::RST_POS_LIN;
            r_gain[1] <= nft_pkg::RST_POS_QUAD;
            r_gain[2] <= nft_pkg::RST_VEL_LIN;
            r_gain[3] <= nft_pkg::RST_VEL_QUAD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nft_pkg::REG_POS_LIN:  r_gain[0] <= i_cfg_data;
                nft_pkg::REG_POS_QUAD: r_gain[1] <= i_cfg_data;
                nft_pkg::REG_VEL_LIN:  r_gain[2] <= i_cfg_data;
                nft_pkg::REG_VEL_QUAD: r_gain[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // follower state: external loads on transfer, update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
        end else if (i_cmd.load) begin
            if (i_in_data.load_position) begin
                r_pos_x <= i_in_data.ext_pos_x;
                r_pos_y <= i_in_data.ext_pos_y;
            end
            if (i_in_data.load_velocity) begin
                r_vel_x <= i_in_data.ext_vel_x;
                r_vel_y <= i_in_data.ext_vel_y;
            end
        end else if (i_cmd.commit) begin
            r_pos_x <= nft_pkg::DATA_W'(r_npx);
            r_pos_y <= nft_pkg::DATA_W'(r_npy);
            r_vel_x <= r_nvx;
            r_vel_y <= r_nvy;
        end
    end

    // multiplier operands
    assign w_k1  = nft_pkg::MUL_W'(r_vsel ? r_gain[2] : r_gain[0]);
    assign w_k2  = nft_pkg::MUL_W'(r_vsel ? r_gain[3] : r_gain[1]);
    assign w_len = $signed({1'b0, w_root});
    assign w_dt  = $signed({17'b0, r_in.time_step});

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (i_cmd.mop.msel)
            nft_pkg::M_EXX:    begin w_a = nft_pkg::MUL_W'(r_ex); w_b = nft_pkg::MUL_W'(r_ex); end
            nft_pkg::M_EYY:    begin w_a = nft_pkg::MUL_W'(r_ey); w_b = nft_pkg::MUL_W'(r_ey); end
            nft_pkg::M_EXL:    begin w_a = nft_pkg::MUL_W'(r_ex); w_b = w_len; end
            nft_pkg::M_EYL:    begin w_a = nft_pkg::MUL_W'(r_ey); w_b = w_len; end
            nft_pkg::M_K1EX:   begin w_a = w_k1; w_b = nft_pkg::MUL_W'(r_ex); end
            nft_pkg::M_K1EY:   begin w_a = w_k1; w_b = nft_pkg::MUL_W'(r_ey); end
            nft_pkg::M_K2PHX:  begin w_a = w_k2; w_b = $signed(r_px[48:16]); end
            nft_pkg::M_K2PLX:  begin w_a = w_k2; w_b = $signed({17'b0, r_px[15:0]}); end
            nft_pkg::M_K2PHY:  begin w_a = w_k2; w_b = $signed(r_py[48:16]); end
            nft_pkg::M_K2PLY:  begin w_a = w_k2; w_b = $signed({17'b0, r_py[15:0]}); end
            nft_pkg::M_VXDT:   begin w_a = nft_pkg::MUL_W'(r_vel_x); w_b = w_dt; end
            nft_pkg::M_VYDT:   begin w_a = nft_pkg::MUL_W'(r_vel_y); w_b = w_dt; end
            nft_pkg::M_AXDT:   begin w_a = nft_pkg::MUL_W'($signed(r_ax[31:0])); w_b = w_dt; end
            nft_pkg::M_AYDT:   begin w_a = nft_pkg::MUL_W'($signed(r_ay[31:0])); w_b = w_dt; end
            nft_pkg::M_ADTXDT: begin w_a = r_adtx; w_b = w_dt; end
            nft_pkg::M_ADTYDT: begin w_a = r_adty; w_b = w_dt; end
            default:           begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_k2sum = r_tmp + r_prod;

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
    end

    // item capture, errors, accumulation and motion
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
            r_ax <= '0;
            r_ay <= '0;
        end
        if (i_cmd.err_ld) begin
            r_vsel <= i_cmd.vsel;
            if (i_cmd.vsel) begin
                r_ex <= nft_pkg::sat32(64'(r_in.target_vx) - 64'(r_vel_x));
                r_ey <= nft_pkg::sat32(64'(r_in.target_vy) - 64'(r_vel_y));
            end else begin
                r_ex <= nft_pkg::sat32(64'(r_in.target_x) - 64'(r_pos_x));
                r_ey <= nft_pkg::sat32(64'(r_in.target_y) - 64'(r_pos_y));
            end
        end
        if (i_cmd.sat_acc) begin
            r_ax <= nft_pkg::ACC_W'(nft_pkg::sat32(64'(r_ax)));
            r_ay <= nft_pkg::ACC_W'(nft_pkg::sat32(64'(r_ay)));
        end
        unique case (i_cmd.mop.usel)
            nft_pkg::U_SQ_SET: r_sq <= r_prod[63:0];
            nft_pkg::U_SQ_ADD: r_sq <= r_sq + r_prod[63:0];
            nft_pkg::U_PX:     r_px <= $signed(r_prod[64:16]);
            nft_pkg::U_PY:     r_py <= $signed(r_prod[64:16]);
            nft_pkg::U_ACCX:   r_ax <= r_ax + $signed(r_prod[65:8]);
            nft_pkg::U_ACCY:   r_ay <= r_ay + $signed(r_prod[65:8]);
            nft_pkg::U_TMPX,
            nft_pkg::U_TMPY:   r_tmp <= $signed({r_prod[49:0], 16'b0});
            nft_pkg::U_K2X:    r_ax <= r_ax + $signed(w_k2sum[65:8]);
            nft_pkg::U_K2Y:    r_ay <= r_ay + $signed(w_k2sum[65:8]);
            nft_pkg::U_VDTX:   r_npx <= 51'(r_pos_x) + 51'($signed(r_prod[65:16]));
            nft_pkg::U_VDTY:   r_npy <= 51'(r_pos_y) + 51'($signed(r_prod[65:16]));
            nft_pkg::U_ADTX: begin
                r_adtx <= $signed(r_prod[48:16]);
                r_nvx  <= nft_pkg::sat32(64'(r_vel_x) + 64'($signed(r_prod[48:16])));
            end
            nft_pkg::U_ADTY: begin
                r_adty <= $signed(r_prod[48:16]);
                r_nvy  <= nft_pkg::sat32(64'(r_vel_y) + 64'($signed(r_prod[48:16])));
            end
            nft_pkg::U_HALFX:
                r_npx <= 51'(nft_pkg::sat32(64'(r_npx) + 64'($signed(r_prod[65:17]))));
            nft_pkg::U_HALFY:
                r_npy <= 51'(nft_pkg::sat32(64'(r_npy) + 64'($signed(r_prod[65:17]))));
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.new_pos_x <= nft_pkg::DATA_W'(r_npx);
            r_out.new_pos_y <= nft_pkg::DATA_W'(r_npy);
            r_out.new_vel_x <= r_nvx;
            r_out.new_vel_y <= r_nvy;
        end
    end

endmodule

// File: rtl/nft_ctrl.sv
module nft_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  nft_pkg::t_stat i_stat,
    output nft_pkg::t_cmd  o_cmd
);

    nft_pkg::t_state             r_state, n_state;
    logic [nft_pkg::STEP_W-1:0]  r_step, n_step;
    logic                        r_vsel, n_vsel;
    logic                        r_ovalid, n_ovalid;
    logic                        w_accept;
    logic                        w_commit;

    assign o_in_ready  = (r_state == nft_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == nft_pkg::ST_DONE) && (!r_ovalid || i_out_ready);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nft_pkg::ST_IDLE;
            r_step   <= '0;
            r_vsel   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_vsel   <= n_vsel;
            r_ovalid <= n_ovalid;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_vsel   = r_vsel;
        n_ovalid = w_commit ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);
        unique case (r_state)
            nft_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = nft_pkg::ST_ERR;
                    n_vsel  = 1'b0;
                end
            end
            nft_pkg::ST_ERR: begin
                n_state = nft_pkg::ST_SQ;
                n_step  = '0;
            end
            nft_pkg::ST_SQ: begin
                if (r_step == nft_pkg::STEP_W'(nft_pkg::SQ_LEN - 1)) begin
                    n_state = nft_pkg::ST_ROOT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            nft_pkg::ST_ROOT: begin
                if (r_step == '0) begin
                    n_step = nft_pkg::STEP_W'(1);
                end else if (!i_stat.root_busy) begin
                    n_state = nft_pkg::ST_PULL;
                    n_step  = '0;
                end
            end
            nft_pkg::ST_PULL: begin
                if (r_step == nft_pkg::STEP_W'(nft_pkg::PULL_LEN - 1)) begin
                    n_step = '0;
                    if (r_vsel) begin
                        n_state = nft_pkg::ST_SAT;
                    end else begin
                        n_state = nft_pkg::ST_ERR;
                        n_vsel  = 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            nft_pkg::ST_SAT: begin
                n_state = nft_pkg::ST_MOVE;
                n_step  = '0;
            end
            nft_pkg::ST_MOVE: begin
                if (r_step == nft_pkg::STEP_W'(nft_pkg::MOVE_LEN - 1)) begin
                    n_state = nft_pkg::ST_DONE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            nft_pkg::ST_DONE: begin
                if (w_commit) begin
                    n_state = nft_pkg::ST_IDLE;
                end
            end
            default: n_state = nft_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_accept;
        o_cmd.vsel    = r_vsel;
        o_cmd.commit  = w_commit;
        o_cmd.mop     = '{msel: nft_pkg::M_NONE, usel: nft_pkg::U_NONE};
        unique case (r_state)
            nft_pkg::ST_ERR:  o_cmd.err_ld  = 1'b1;
            nft_pkg::ST_SQ:   o_cmd.mop     = nft_pkg::sq_op(r_step);
            nft_pkg::ST_ROOT: o_cmd.root_go = (r_step == '0);
            nft_pkg::ST_PULL: o_cmd.mop     = nft_pkg::pull_op(r_step);
            nft_pkg::ST_SAT:  o_cmd.sat_acc = 1'b1;
            nft_pkg::ST_MOVE: o_cmd.mop     = nft_pkg::move_op(r_step);
            default: ;
        endcase
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_ovalid || i_out_ready))
        else $error("result committed over an untaken result");

    a_load_then_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == nft_pkg::ST_ERR) && !r_vsel)
        else $error("transfer did not start the error phase");

    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nft_pkg::ST_PULL) |-> !i_stat.root_busy)
        else $error("pull terms started before square root finished");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_ovalid && (r_state == nft_pkg::ST_IDLE))
        else $error("commit did not raise result valid");

endmodule

// File: rtl/nonlinear_follow_tracker_2d.sv
// channel   direction  handshake                  payload
// cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_data (16 bit gain)
// in        in         i_in_valid / o_in_ready    i_in_data  (nft_pkg::t_in)
// out       out        o_out_valid / i_out_ready  o_out_data (nft_pkg::t_out)
//
// One item runs from transfer to result valid in two passes of error
// load, squares, 32-step square root and pull terms, then saturation, motion and
// commit; the next transfer is taken once the block is back in idle after the commit.
// Reset is synchronous, active low; it restores the default gains and zeroes the follower.
// A waiting result holds in the output register while the next item computes;
// the commit of that item waits until the result is taken.
module nonlinear_follow_tracker_2d (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nft_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nft_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nft_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nft_pkg::t_out                 o_out_data
);

    nft_pkg::t_cmd  w_cmd;
    nft_pkg::t_stat w_stat;

    nft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    nft_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule
